>>> design/gouraud_triangle_rasterizer_core_defines.svh
// Assertion macros shared by the rasterizer RTL.
`ifndef GOURAUD_TRIANGLE_RASTERIZER_CORE_DEFINES_SVH
`define GOURAUD_TRIANGLE_RASTERIZER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define GTR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define GTR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/gtr_pkg.sv
package gtr_pkg;

	// Fixed field widths of the channels.
	localparam int COORD_W = 11;
	localparam int SHADE_W = 3;
	localparam int PIX_W   = 8;
	localparam int IDX_W   = 17;

	// Written intensity range and its position in the stored byte.
	localparam int LVL_MIN   = 1;
	localparam int LVL_MAX   = 7;
	localparam int LVL_SHIFT = 2;

	// Operation codes.
	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_DRAW  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	typedef enum logic [4:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_READ,
		ST_SETUP,
		ST_LAUNCH,
		ST_DIV,
		ST_LOWER,
		ST_ROW,
		ST_SPAN,
		ST_CLIPMUL,
		ST_CLIPADD,
		ST_SPAN2,
		ST_PIXSET,
		ST_PIX,
		ST_ADV,
		ST_DONE
	} state_t;

	// Which quotient the shared divider is producing.
	typedef enum logic [2:0] {
		TAG_SX02,
		TAG_SC02,
		TAG_SXE,
		TAG_SCE,
		TAG_CLIP,
		TAG_SLOPE
	} div_tag_t;

endpackage

>>> design/gtr_req_if.sv
interface gtr_req_if;
	logic valid;
	logic ready;
	logic [1:0] op;
	logic signed [gtr_pkg::COORD_W-1:0] v0_x;
	logic signed [gtr_pkg::COORD_W-1:0] v0_y;
	logic signed [gtr_pkg::COORD_W-1:0] v1_x;
	logic signed [gtr_pkg::COORD_W-1:0] v1_y;
	logic signed [gtr_pkg::COORD_W-1:0] v2_x;
	logic signed [gtr_pkg::COORD_W-1:0] v2_y;
	logic [gtr_pkg::SHADE_W-1:0] shade0;
	logic [gtr_pkg::SHADE_W-1:0] shade1;
	logic [gtr_pkg::SHADE_W-1:0] shade2;
	logic back_face;
	logic [gtr_pkg::IDX_W-1:0] read_index;

	modport source (output valid, op, v0_x, v0_y, v1_x, v1_y, v2_x, v2_y,
		shade0, shade1, shade2, back_face, read_index, input ready);
	modport sink (input valid, op, v0_x, v0_y, v1_x, v1_y, v2_x, v2_y,
		shade0, shade1, shade2, back_face, read_index, output ready);
endinterface

>>> design/gtr_rsp_if.sv
interface gtr_rsp_if;
	logic valid;
	logic ready;
	logic [gtr_pkg::PIX_W-1:0] pixel_value;

	modport source (output valid, pixel_value, input ready);
	modport sink (input valid, pixel_value, output ready);
endinterface

>>> design/gtr_div.sv
module gtr_div #(
	parameter int NUM_W = 20,
	parameter int DEN_W = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic done,
	output logic signed [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic busy_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] mag_q;
	logic [NUM_W-1:0] q_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic neg_q;
	logic [DEN_W:0] rem_sh;
	logic fits;

	// One quotient bit per cycle, restoring form on the magnitude.
	assign rem_sh = {rem_q, mag_q[NUM_W-1]};
	assign fits = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and partial-result registers.
	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= num[NUM_W-1] ? $unsigned(-num) : $unsigned(num);
			neg_q <= num[NUM_W-1];
			den_q <= den;
			rem_q <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			mag_q <= {mag_q[NUM_W-2:0], 1'b0};
			q_q   <= {q_q[NUM_W-2:0], fits};
			rem_q <= fits ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
		end
	end

	// Truncation toward zero: the sign goes back on the magnitude quotient.
	assign done = done_q;
	assign quo = neg_q ? -$signed(q_q) : $signed(q_q);

endmodule

>>> design/gouraud_triangle_rasterizer_core.sv
// Channel  Role    Payload                                   Transfer when
// req      sink    op, vertices, shades, back_face, index    valid & ready
// rsp      source  pixel_value                               valid & ready
//
// After reset the frame store is swept to zero, one byte a cycle;
// req.ready stays low meanwhile. Clear takes the same sweep; a read goes from the
// registered read port through ST_READ and ST_DONE into the rsp register.
// A triangle takes up to 6 divider runs, ST_ROW and ST_ADV for each row off screen,
// the span states from ST_ROW to ST_ADV for each visible row (with ST_CLIPMUL and
// ST_CLIPADD for a left clip), up to 2 more divider runs per visible span and one
// span pixel per cycle. One item is in work at a time; a result waits in the
// rsp register while the next request is taken.
`include "gouraud_triangle_rasterizer_core_defines.svh"

module gouraud_triangle_rasterizer_core #(
	parameter int FB_WIDTH  = 320,
	parameter int FB_HEIGHT = 240,
	parameter int FRAC_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,
	gtr_req_if.sink req,
	gtr_rsp_if.source rsp
);

	localparam int FB_SIZE = FB_WIDTH * FB_HEIGHT;
	localparam int A_W     = $clog2(FB_SIZE);
	localparam int X_W     = $clog2(FB_WIDTH);
	localparam int Y_W     = $clog2(FB_HEIGHT);
	localparam int CW      = gtr_pkg::COORD_W;
	localparam int NUM_W   = CW + 1 + FRAC_BITS;
	localparam int DEN_W   = CW + 1;
	localparam int ACC_W   = NUM_W + 1;
	localparam int POS_W   = ACC_W - FRAC_BITS;
	localparam int RI_W    = (gtr_pkg::IDX_W > A_W) ? gtr_pkg::IDX_W : A_W;
	localparam int PW      = gtr_pkg::PIX_W;
	localparam logic signed [POS_W-1:0] H_S    = POS_W'(FB_HEIGHT);
	localparam logic signed [POS_W-1:0] WMAX_S = POS_W'(FB_WIDTH - 1);

	gtr_pkg::state_t state_q, state_d;
	gtr_pkg::div_tag_t tag_q;
	logic part_q;
	logic back_q;
	logic inr_q;
	logic [PW-1:0] res_q;
	logic ov_q;
	logic [PW-1:0] pix_q;
	logic [A_W-1:0] addr_q;

	logic signed [CW-1:0] vx_q [3];
	logic signed [CW-1:0] vy_q [3];
	logic [gtr_pkg::SHADE_W-1:0] vs_q [3];
	logic signed [CW-1:0] sx_c [3];
	logic signed [CW-1:0] sy_c [3];
	logic [gtr_pkg::SHADE_W-1:0] ss_c [3];

	logic signed [NUM_W-1:0] sx02_q, sc02_q, sxe_q, sce_q, slope_q;
	logic signed [ACC_W-1:0] ax_q, bx_q, ac_q, bc_q, ca_q, cb_q, c_q, prod_q;
	logic signed [POS_W-1:0] row_q, xa_q, xb_q, px_q;

	logic [PW-1:0] mem [FB_SIZE];
	logic [PW-1:0] rd_q;
	logic mem_we;
	logic [A_W-1:0] mem_waddr;
	logic [PW-1:0] mem_wdata;
	logic [RI_W-1:0] ridx;
	logic [A_W-1:0] mem_raddr;
	logic rd_inr;

	logic div_start;
	logic div_done;
	logic signed [NUM_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic signed [NUM_W-1:0] div_quo;

	logic acc;
	logic out_free;
	logic addr_last;
	logic total_zero, h1_pos, h2_pos;
	logic row_end, row_off;
	logic signed [POS_W-1:0] fa, fb, span_xa, span_xb, xbc;
	logic signed [ACC_W-1:0] span_ca, span_cb;
	logic signed [ACC_W-1:0] mul_a, mul_b;
	logic signed [POS_W-1:0] lvl;
	logic [2:0] lvl_c;
	logic dith_on;

	assign acc       = req.valid && req.ready;
	assign out_free  = !ov_q || rsp.ready;
	assign addr_last = addr_q == A_W'(FB_SIZE - 1);

	// Sort of the incoming vertices by row.
	always_comb begin
		logic signed [CW-1:0] tx, ty;
		logic [gtr_pkg::SHADE_W-1:0] ts;
		tx = '0;
		ty = '0;
		ts = '0;
		sx_c = '{req.v0_x, req.v1_x, req.v2_x};
		sy_c = '{req.v0_y, req.v1_y, req.v2_y};
		ss_c = '{req.shade0, req.shade1, req.shade2};
		if (sy_c[0] > sy_c[1]) begin
			tx = sx_c[0]; sx_c[0] = sx_c[1]; sx_c[1] = tx;
			ty = sy_c[0]; sy_c[0] = sy_c[1]; sy_c[1] = ty;
			ts = ss_c[0]; ss_c[0] = ss_c[1]; ss_c[1] = ts;
		end
		if (sy_c[0] > sy_c[2]) begin
			tx = sx_c[0]; sx_c[0] = sx_c[2]; sx_c[2] = tx;
			ty = sy_c[0]; sy_c[0] = sy_c[2]; sy_c[2] = ty;
			ts = ss_c[0]; ss_c[0] = ss_c[2]; ss_c[2] = ts;
		end
		if (sy_c[1] > sy_c[2]) begin
			tx = sx_c[1]; sx_c[1] = sx_c[2]; sx_c[2] = tx;
			ty = sy_c[1]; sy_c[1] = sy_c[2]; sy_c[2] = ty;
			ts = ss_c[1]; ss_c[1] = ss_c[2]; ss_c[2] = ts;
		end
	end

	// Triangle shape and row-loop conditions.
	assign total_zero = vy_q[2] == vy_q[0];
	assign h1_pos     = vy_q[1] != vy_q[0];
	assign h2_pos     = vy_q[2] != vy_q[1];
	assign row_end    = part_q ? (row_q > POS_W'(vy_q[2])) : (row_q >= POS_W'(vy_q[1]));
	assign row_off    = (row_q < 0) || (row_q >= H_S);

	// Span ends: floor of the edge positions, ordered left to right.
	always_comb begin
		fa = ax_q[ACC_W-1:FRAC_BITS];
		fb = bx_q[ACC_W-1:FRAC_BITS];
		if (fa > fb) begin
			span_xa = fb; span_xb = fa; span_ca = bc_q; span_cb = ac_q;
		end else begin
			span_xa = fa; span_xb = fb; span_ca = ac_q; span_cb = bc_q;
		end
	end

	assign xbc = (xb_q > WMAX_S) ? WMAX_S : xb_q;

	// Divider operands by the quotient being produced.
	always_comb begin
		case (tag_q)
			gtr_pkg::TAG_SX02: begin
				div_num = (NUM_W'(vx_q[2]) - NUM_W'(vx_q[0])) <<< FRAC_BITS;
				div_den = DEN_W'(vy_q[2]) - DEN_W'(vy_q[0]);
			end
			gtr_pkg::TAG_SC02: begin
				div_num = (NUM_W'($signed({1'b0, vs_q[2]}))
					- NUM_W'($signed({1'b0, vs_q[0]}))) <<< FRAC_BITS;
				div_den = DEN_W'(vy_q[2]) - DEN_W'(vy_q[0]);
			end
			gtr_pkg::TAG_SXE: begin
				if (part_q) begin
					div_num = (NUM_W'(vx_q[2]) - NUM_W'(vx_q[1])) <<< FRAC_BITS;
					div_den = DEN_W'(vy_q[2]) - DEN_W'(vy_q[1]);
				end else begin
					div_num = (NUM_W'(vx_q[1]) - NUM_W'(vx_q[0])) <<< FRAC_BITS;
					div_den = DEN_W'(vy_q[1]) - DEN_W'(vy_q[0]);
				end
			end
			gtr_pkg::TAG_SCE: begin
				if (part_q) begin
					div_num = (NUM_W'($signed({1'b0, vs_q[2]}))
						- NUM_W'($signed({1'b0, vs_q[1]}))) <<< FRAC_BITS;
					div_den = DEN_W'(vy_q[2]) - DEN_W'(vy_q[1]);
				end else begin
					div_num = (NUM_W'($signed({1'b0, vs_q[1]}))
						- NUM_W'($signed({1'b0, vs_q[0]}))) <<< FRAC_BITS;
					div_den = DEN_W'(vy_q[1]) - DEN_W'(vy_q[0]);
				end
			end
			default: begin
				div_num = NUM_W'(cb_q - ca_q);
				div_den = DEN_W'(xb_q - xa_q);
			end
		endcase
	end

	gtr_div #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num),
		.den(div_den),
		.done(div_done),
		.quo(div_quo)
	);

	// Pixel level and dither mask.
	assign lvl = c_q[ACC_W-1:FRAC_BITS];
	always_comb begin
		if (lvl < POS_W'(gtr_pkg::LVL_MIN)) begin
			lvl_c = 3'(gtr_pkg::LVL_MIN);
		end else if (lvl > POS_W'(gtr_pkg::LVL_MAX)) begin
			lvl_c = 3'(gtr_pkg::LVL_MAX);
		end else begin
			lvl_c = lvl[2:0];
		end
	end
	assign dith_on = back_q ? (!px_q[0] && !row_q[0]) : (px_q[0] ^ row_q[0]);

	assign mul_a = ACC_W'(slope_q);
	assign mul_b = ACC_W'(-xa_q);

	// Read port address from the request.
	assign ridx      = RI_W'(req.read_index);
	assign mem_raddr = ridx[A_W-1:0];
	assign rd_inr    = ridx < RI_W'(FB_SIZE);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gtr_pkg::ST_INIT: if (addr_last) state_d = gtr_pkg::ST_IDLE;
			gtr_pkg::ST_IDLE: begin
				if (acc) begin
					case (req.op)
						gtr_pkg::OP_CLEAR: state_d = gtr_pkg::ST_CLEAR;
						gtr_pkg::OP_DRAW:  state_d = gtr_pkg::ST_SETUP;
						gtr_pkg::OP_READ:  state_d = gtr_pkg::ST_READ;
						default:           state_d = gtr_pkg::ST_DONE;
					endcase
				end
			end
			gtr_pkg::ST_CLEAR: if (addr_last) state_d = gtr_pkg::ST_DONE;
			gtr_pkg::ST_READ: state_d = gtr_pkg::ST_DONE;
			gtr_pkg::ST_SETUP: state_d = total_zero ? gtr_pkg::ST_DONE : gtr_pkg::ST_LAUNCH;
			gtr_pkg::ST_LAUNCH: state_d = gtr_pkg::ST_DIV;
			gtr_pkg::ST_DIV: begin
				if (div_done) begin
					unique case (tag_q)
						gtr_pkg::TAG_SX02, gtr_pkg::TAG_SXE: state_d = gtr_pkg::ST_LAUNCH;
						gtr_pkg::TAG_SC02:
							state_d = h1_pos ? gtr_pkg::ST_LAUNCH : gtr_pkg::ST_LOWER;
						gtr_pkg::TAG_SCE:  state_d = gtr_pkg::ST_ROW;
						gtr_pkg::TAG_CLIP: state_d = gtr_pkg::ST_CLIPMUL;
						default:           state_d = gtr_pkg::ST_PIXSET;
					endcase
				end
			end
			gtr_pkg::ST_LOWER: state_d = h2_pos ? gtr_pkg::ST_LAUNCH : gtr_pkg::ST_DONE;
			gtr_pkg::ST_ROW: begin
				if (row_end) begin
					state_d = part_q ? gtr_pkg::ST_DONE : gtr_pkg::ST_LOWER;
				end else begin
					state_d = row_off ? gtr_pkg::ST_ADV : gtr_pkg::ST_SPAN;
				end
			end
			gtr_pkg::ST_SPAN: begin
				if (xa_q < 0 && xb_q > xa_q) state_d = gtr_pkg::ST_LAUNCH;
				else state_d = gtr_pkg::ST_SPAN2;
			end
			gtr_pkg::ST_CLIPMUL: state_d = gtr_pkg::ST_CLIPADD;
			gtr_pkg::ST_CLIPADD: state_d = gtr_pkg::ST_SPAN2;
			gtr_pkg::ST_SPAN2: begin
				if (xa_q > xbc) state_d = gtr_pkg::ST_ADV;
				else if (xbc > xa_q) state_d = gtr_pkg::ST_LAUNCH;
				else state_d = gtr_pkg::ST_PIXSET;
			end
			gtr_pkg::ST_PIXSET: state_d = gtr_pkg::ST_PIX;
			gtr_pkg::ST_PIX: if (px_q == xb_q) state_d = gtr_pkg::ST_ADV;
			gtr_pkg::ST_ADV: state_d = gtr_pkg::ST_ROW;
			gtr_pkg::ST_DONE: if (out_free) state_d = gtr_pkg::ST_IDLE;
			default: state_d = gtr_pkg::ST_IDLE;
		endcase
	end

	// State-machine outputs: handshake, divider start and store write port.
	always_comb begin
		req.ready = state_q == gtr_pkg::ST_IDLE;
		div_start = state_q == gtr_pkg::ST_LAUNCH;
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		unique case (state_q)
			gtr_pkg::ST_INIT, gtr_pkg::ST_CLEAR: mem_we = 1'b1;
			gtr_pkg::ST_PIX: begin
				mem_we    = dith_on;
				mem_wdata = PW'({lvl_c, 2'b00});
			end
			default: mem_we = 1'b0;
		endcase
	end

	assign rsp.valid       = ov_q;
	assign rsp.pixel_value = pix_q;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gtr_pkg::ST_INIT;
			addr_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp.ready) ov_q <= 1'b0;
			if (state_q == gtr_pkg::ST_DONE && out_free) ov_q <= 1'b1;
			case (state_q)
				gtr_pkg::ST_INIT, gtr_pkg::ST_CLEAR: addr_q <= addr_q + 1'b1;
				gtr_pkg::ST_IDLE: addr_q <= '0;
				gtr_pkg::ST_PIXSET:
					addr_q <= A_W'(row_q[Y_W-1:0] * FB_WIDTH) + A_W'(xa_q[X_W-1:0]);
				gtr_pkg::ST_PIX: addr_q <= addr_q + 1'b1;
				default: addr_q <= addr_q;
			endcase
		end
	end

	// Frame store: one write and one registered read a cycle.
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rd_q <= mem[mem_raddr];
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == gtr_pkg::ST_DONE && out_free) pix_q <= res_q;
		case (state_q)
			gtr_pkg::ST_IDLE: begin
				if (acc) begin
					vx_q   <= sx_c;
					vy_q   <= sy_c;
					vs_q   <= ss_c;
					back_q <= req.back_face;
					inr_q  <= rd_inr;
					res_q  <= '0;
				end
			end
			gtr_pkg::ST_READ: res_q <= inr_q ? rd_q : '0;
			gtr_pkg::ST_SETUP: begin
				tag_q  <= gtr_pkg::TAG_SX02;
				part_q <= 1'b0;
				ax_q   <= ACC_W'(vx_q[0]) <<< FRAC_BITS;
				bx_q   <= ACC_W'(vx_q[0]) <<< FRAC_BITS;
				ac_q   <= ACC_W'($signed({1'b0, vs_q[0]})) <<< FRAC_BITS;
				bc_q   <= ACC_W'($signed({1'b0, vs_q[0]})) <<< FRAC_BITS;
				row_q  <= POS_W'(vy_q[0]);
			end
			gtr_pkg::ST_DIV: begin
				if (div_done) begin
					case (tag_q)
						gtr_pkg::TAG_SX02: begin
							sx02_q <= div_quo;
							tag_q  <= gtr_pkg::TAG_SC02;
						end
						gtr_pkg::TAG_SC02: begin
							sc02_q <= div_quo;
							tag_q  <= gtr_pkg::TAG_SXE;
						end
						gtr_pkg::TAG_SXE: begin
							sxe_q <= div_quo;
							tag_q <= gtr_pkg::TAG_SCE;
						end
						gtr_pkg::TAG_SCE: sce_q <= div_quo;
						default: slope_q <= div_quo;
					endcase
				end
			end
			gtr_pkg::ST_LOWER: begin
				part_q <= 1'b1;
				tag_q  <= gtr_pkg::TAG_SXE;
				bx_q   <= ACC_W'(vx_q[1]) <<< FRAC_BITS;
				bc_q   <= ACC_W'($signed({1'b0, vs_q[1]})) <<< FRAC_BITS;
				row_q  <= POS_W'(vy_q[1]);
			end
			gtr_pkg::ST_ROW: begin
				xa_q <= span_xa;
				xb_q <= span_xb;
				ca_q <= span_ca;
				cb_q <= span_cb;
			end
			gtr_pkg::ST_SPAN: begin
				if (xa_q < 0) begin
					if (xb_q > xa_q) tag_q <= gtr_pkg::TAG_CLIP;
					else xa_q <= '0;
				end
			end
			gtr_pkg::ST_CLIPMUL: prod_q <= mul_a * mul_b;
			gtr_pkg::ST_CLIPADD: begin
				ca_q <= ca_q + prod_q;
				xa_q <= '0;
			end
			gtr_pkg::ST_SPAN2: begin
				xb_q    <= xbc;
				tag_q   <= gtr_pkg::TAG_SLOPE;
				slope_q <= '0;
			end
			gtr_pkg::ST_PIXSET: begin
				c_q  <= ca_q;
				px_q <= xa_q;
			end
			gtr_pkg::ST_PIX: begin
				c_q  <= c_q + ACC_W'(slope_q);
				px_q <= px_q + 1'b1;
			end
			gtr_pkg::ST_ADV: begin
				ax_q  <= ax_q + ACC_W'(sx02_q);
				bx_q  <= bx_q + ACC_W'(sxe_q);
				ac_q  <= ac_q + ACC_W'(sc02_q);
				bc_q  <= bc_q + ACC_W'(sce_q);
				row_q <= row_q + 1'b1;
			end
			default: ;
		endcase
	end

	// Every accepted request moves the controller out of idle.
	`GTR_ASSERT_NXT(a_acc_leaves_idle, acc, state_q != gtr_pkg::ST_IDLE, "accept stayed idle")
	// The store is written only by a sweep or by span pixels.
	`GTR_ASSERT_NOW(a_we_state, mem_we, (state_q == gtr_pkg::ST_INIT) || (state_q == gtr_pkg::ST_CLEAR) || (state_q == gtr_pkg::ST_PIX), "store write outside sweep or span")
	// Span pixels stay on a visible row.
	`GTR_ASSERT_NOW(a_pix_row, state_q == gtr_pkg::ST_PIX, (row_q >= 0) && (row_q < H_S) && (px_q >= 0) && (px_q <= WMAX_S), "pixel off screen")
	// A result appears only as the controller finishes an item.
	`GTR_ASSERT_NOW(a_rsp_from_done, $rose(ov_q), $past(state_q) == gtr_pkg::ST_DONE, "result without finished item")

endmodule
